// ===== sv/pkht_pkg.sv =====
// ----------------------------------------------------------------------------
// pkht_pkg
// Types and constants shared by the pair-keyed hash table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pkht_pkg;

  // Command codes of an input transaction.
  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_FIND     = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_CLEAR    = 3'd3,
    CMD_IS_EMPTY = 3'd4,
    CMD_UPDATE   = 3'd5
  } cmd_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NUM_BUCKETS = 2'd0;
  localparam logic [1:0] CFG_PRIME_A     = 2'd1;
  localparam logic [1:0] CFG_PRIME_B     = 2'd2;

  localparam int CFG_DATA_W = 16;
  localparam int NB_CFG_W   = 9;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] first_id;
    logic [15:0] second_id;
    logic [15:0] payload;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [15:0] payload_out;
    logic [7:0]  bucket_index;
    logic        table_empty;
    logic        overflow;
  } out_t;

  // One stored entry of a bucket.
  typedef struct packed {
    logic [15:0] first_id;
    logic [15:0] second_id;
    logic [15:0] handle;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/pair_keyed_chained_hash_table.sv =====
// Hashing: two multiplies, then a 33-step serial modulo. Find and remove scan
// the entries of their bucket; clear and update pass over every bucket; insert,
// is_empty and unknown commands need no scan.
// Overlap: the next command is hashed while the previous one runs, through
// a two-entry queue; results cannot be stalled.
// Reset: a clearing pass over every bucket of the bucket memory, busy high.
// ----------------------------------------------------------------------------
// pair_keyed_chained_hash_table
// Hash table keyed by an ordered id pair, with chained buckets of fixed depth.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_keyed_chained_hash_table #(
  parameter int BUCKETS      = 256,
  parameter int BUCKET_DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire pkht_pkg::in_t                     in_item,
  output logic                                   out_valid,
  output pkht_pkg::out_t                         out_result,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_idx,
  input  wire logic [pkht_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pkht_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam int QW = $bits(in_t) + BW;

  logic [NB_CFG_W-1:0] num_buckets_r;
  logic [15:0]         prime_a_r, prime_b_r;
  logic                front_busy, init_busy, accept;
  logic                push, pop, q_empty, q_full;
  in_t                 push_item;
  logic [BW-1:0]       push_bucket;
  logic [QW-1:0]       q_data;

  assign busy   = front_busy || init_busy;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_buckets_r <= NB_CFG_W'(256);
      prime_a_r     <= 16'd73;
      prime_b_r     <= 16'd151;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NUM_BUCKETS: num_buckets_r <= cfg_data[NB_CFG_W-1:0];
        CFG_PRIME_A:     prime_a_r     <= cfg_data;
        CFG_PRIME_B:     prime_b_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pkht_front #(.BUCKETS(BUCKETS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_item),
    .num_buckets (num_buckets_r),
    .prime_a     (prime_a_r),
    .prime_b     (prime_b_r),
    .full        (q_full),
    .busy        (front_busy),
    .push        (push),
    .push_item   (push_item),
    .push_bucket (push_bucket)
  );

  pkht_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_bucket, push_item}),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  pkht_back #(.BUCKETS(BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (in_t'(q_data[$bits(in_t)-1:0])),
    .q_bucket   (q_data[QW-1:$bits(in_t)]),
    .q_pop      (pop),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

`default_nettype wire

// ===== sv/pkht_front.sv =====
// ----------------------------------------------------------------------------
// pkht_front
// Accepts a command, hashes its key pair with a bit-serial modulo unit and
// hands the command with its bucket to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pkht_front #(
  parameter int BUCKETS = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            accept,
  input  wire pkht_pkg::in_t                   item,
  input  wire logic [pkht_pkg::NB_CFG_W-1:0]   num_buckets,
  input  wire logic [15:0]                     prime_a,
  input  wire logic [15:0]                     prime_b,
  input  wire logic                            full,
  output logic                                 busy,
  output logic                                 push,
  output pkht_pkg::in_t                        push_item,
  output logic [$clog2(BUCKETS)-1:0]           push_bucket
);
  import pkht_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam int NW = $clog2(BUCKETS + 1);
  localparam int DW = 33;
  localparam int SW = $clog2(DW);

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_SUM, F_MOD, F_PUSH} fstate_t;

  fstate_t        state_r;
  in_t            item_r;
  logic [31:0]    pa_r, pb_r;
  logic [DW-1:0]  dvd_r;
  logic [NW-1:0]  rem_r;
  logic [SW-1:0]  step_r;
  logic [NW-1:0]  modn;
  logic [NW:0]    remsh;
  logic [NW:0]    remsub;

  // Effective modulus: zero acts as one, large values saturate.
  always_comb begin
    if (num_buckets == '0) begin
      modn = NW'(1);
    end else if (32'(num_buckets) > 32'(BUCKETS)) begin
      modn = NW'(BUCKETS);
    end else begin
      modn = NW'(num_buckets);
    end
  end

  // One restoring modulo step per cycle.
  assign remsh  = {rem_r, dvd_r[DW-1]};
  assign remsub = (remsh >= {1'b0, modn}) ? (remsh - {1'b0, modn}) : remsh;

  assign busy        = (state_r != F_IDLE);
  assign push        = (state_r == F_PUSH) && !full;
  assign push_item   = item_r;
  assign push_bucket = BW'(rem_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            item_r  <= item;
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          pa_r    <= 32'(item_r.first_id) * 32'(prime_a);
          pb_r    <= 32'(item_r.second_id) * 32'(prime_b);
          state_r <= F_SUM;
        end
        F_SUM: begin
          // The sum of both products gives the same remainder as the sum
          // of the two remainders.
          dvd_r   <= DW'(pa_r) + DW'(pb_r);
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= F_MOD;
        end
        F_MOD: begin
          rem_r  <= NW'(remsub);
          dvd_r  <= {dvd_r[DW-2:0], 1'b0};
          step_r <= step_r + 1'b1;
          if (step_r == SW'(DW - 1)) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_PUSH) |-> (rem_r < modn))
    else $error("bucket not below modulus");
  a_push_once: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (state_r == F_IDLE))
    else $error("front did not return to idle after push");
  a_mod_steps: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == F_PUSH) |-> $past(step_r) == SW'(DW - 1))
    else $error("modulo ended early");
`endif

endmodule

`default_nettype wire

// ===== sv/pkht_queue.sv =====
// ----------------------------------------------------------------------------
// pkht_queue
// Two-entry queue between the hashing front and the table back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pkht_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty,
  output logic              full
);

  logic [W-1:0] slot_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign pop_data = slot_r[rp_r];

  // Data storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== sv/pkht_back.sv =====
// ----------------------------------------------------------------------------
// pkht_back
// Carries out table commands on the bucket and entry memories and issues
// one result per command.
// ----------------------------------------------------------------------------
`default_nettype none

module pkht_back #(
  parameter int BUCKETS      = 256,
  parameter int BUCKET_DEPTH = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  wire pkht_pkg::in_t                q_item,
  input  wire logic [$clog2(BUCKETS)-1:0]   q_bucket,
  output logic                              q_pop,
  output logic                              init_busy,
  output logic                              out_valid,
  output pkht_pkg::out_t                    out_result
);
  import pkht_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam int KW = $clog2(BUCKET_DEPTH + 1);
  localparam int AW = $clog2(BUCKETS * BUCKET_DEPTH);
  localparam int UW = $clog2(BUCKETS + 1);
  localparam int SLOTS = BUCKETS * BUCKET_DEPTH;
  localparam logic [AW-1:0] DEPTH_A = AW'(BUCKET_DEPTH);
  localparam logic [KW-1:0] DEPTH_K = KW'(BUCKET_DEPTH);
  localparam logic [BW-1:0] LAST_B  = BW'(BUCKETS - 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_BRD, S_SRD, S_SCMP, S_MRD, S_MWR, S_CRD, S_CCHK, S_RESP
  } bstate_t;

  bstate_t       state_r;
  logic [2:0]    cmd_r;
  logic [15:0]   a_r, b_r, pl_r;
  logic [BW-1:0] bk_r, idx_r;
  logic [KW-1:0] cnt_r, k_r;
  logic          used_r;
  logic          found_r, ovf_r;
  logic [15:0]   pout_r;
  logic [UW-1:0] used_cnt_r;
  logic          out_valid_r;
  out_t          out_r;

  // Bucket memory: used mark and entry count per bucket.
  logic [KW:0]   bmem [BUCKETS];
  logic [KW:0]   bq;
  logic          b_we;
  logic [BW-1:0] b_ra, b_wa;
  logic [KW:0]   b_wd;
  logic          bq_used;
  logic [KW-1:0] bq_cnt;

  // Entry memory: one word per slot.
  entry_t        emem [SLOTS];
  entry_t        eq;
  logic          e_we;
  logic [AW-1:0] e_ra, e_wa;
  entry_t        e_wd;
  logic [KW-1:0] k_inc;

  assign bq_used = bq[KW];
  assign bq_cnt  = bq[KW-1:0];
  assign k_inc   = k_r + 1'b1;

  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[b_wa] <= b_wd;
    end
    bq <= bmem[b_ra];
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      emem[e_wa] <= e_wd;
    end
    eq <= emem[e_ra];
  end

  // Memory port control.
  always_comb begin
    b_ra = (state_r == S_IDLE) ? q_bucket : idx_r;
    b_we = 1'b0;
    b_wa = bk_r;
    b_wd = '0;
    e_ra = AW'(bk_r) * DEPTH_A + AW'((state_r == S_MRD) ? k_inc : k_r);
    e_we = 1'b0;
    e_wa = AW'(bk_r) * DEPTH_A + AW'((state_r == S_BRD) ? bq_cnt : k_r);
    e_wd = eq;
    case (state_r)
      S_INIT: begin
        b_we = 1'b1;
        b_wa = idx_r;
      end
      S_BRD: begin
        if (cmd_r == CMD_INSERT) begin
          b_we = 1'b1;
          if (bq_cnt < DEPTH_K) begin
            e_we = 1'b1;
            e_wd = '{first_id: a_r, second_id: b_r, handle: pl_r};
            b_wd = {1'b1, bq_cnt + 1'b1};
          end else begin
            b_wd = {1'b1, bq_cnt};
          end
        end
      end
      S_MRD: begin
        if (k_inc >= cnt_r) begin
          b_we = 1'b1;
          b_wd = {used_r, cnt_r - 1'b1};
        end
      end
      S_MWR: begin
        e_we = 1'b1;
      end
      S_CCHK: begin
        b_wa = idx_r;
        if (cmd_r == CMD_CLEAR) begin
          b_we = 1'b1;
          b_wd = {1'b0, bq_used ? {KW{1'b0}} : bq_cnt};
        end else if (bq_used && (bq_cnt == '0)) begin
          b_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign q_pop      = (state_r == S_IDLE) && !q_empty;
  assign init_busy  = (state_r == S_INIT);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      used_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_INIT: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_B) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r   <= q_item.cmd;
            a_r     <= q_item.first_id;
            b_r     <= q_item.second_id;
            pl_r    <= q_item.payload;
            bk_r    <= q_bucket;
            found_r <= 1'b0;
            ovf_r   <= 1'b0;
            pout_r  <= '0;
            state_r <= S_BRD;
          end
        end
        S_BRD: begin
          cnt_r  <= bq_cnt;
          used_r <= bq_used;
          k_r    <= '0;
          idx_r  <= '0;
          case (cmd_r)
            CMD_INSERT: begin
              ovf_r <= !(bq_cnt < DEPTH_K);
              if (!bq_used) begin
                used_cnt_r <= used_cnt_r + 1'b1;
              end
              state_r <= S_RESP;
            end
            CMD_FIND, CMD_REMOVE: state_r <= S_SRD;
            CMD_CLEAR, CMD_UPDATE: state_r <= S_CRD;
            default: state_r <= S_RESP;
          endcase
        end
        S_SRD: begin
          state_r <= (k_r == cnt_r) ? S_RESP : S_SCMP;
        end
        S_SCMP: begin
          if (eq.first_id == a_r && eq.second_id == b_r) begin
            found_r <= 1'b1;
            if (cmd_r == CMD_FIND) begin
              pout_r  <= eq.handle;
              state_r <= S_RESP;
            end else begin
              state_r <= S_MRD;
            end
          end else begin
            k_r     <= k_inc;
            state_r <= S_SRD;
          end
        end
        S_MRD: begin
          state_r <= (k_inc >= cnt_r) ? S_RESP : S_MWR;
        end
        S_MWR: begin
          k_r     <= k_inc;
          state_r <= S_MRD;
        end
        S_CRD: begin
          state_r <= S_CCHK;
        end
        S_CCHK: begin
          if (cmd_r == CMD_UPDATE && bq_used && (bq_cnt == '0)) begin
            used_cnt_r <= used_cnt_r - 1'b1;
          end
          if (idx_r == LAST_B) begin
            if (cmd_r == CMD_CLEAR) begin
              used_cnt_r <= '0;
            end
            state_r <= S_RESP;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_CRD;
          end
        end
        S_RESP: begin
          out_valid_r        <= 1'b1;
          out_r.found        <= found_r;
          out_r.payload_out  <= pout_r;
          out_r.bucket_index <= 8'(bk_r);
          out_r.table_empty  <= (used_cnt_r == '0);
          out_r.overflow     <= ovf_r;
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_RESP))
    else $error("result issued outside response step");
  a_used_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_cnt_r <= UW'(BUCKETS))
    else $error("used bucket count out of range");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRD) |-> (k_r <= cnt_r && cnt_r <= DEPTH_K))
    else $error("scan index beyond bucket count");
  a_found_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.found && out_r.overflow))
    else $error("found and overflow together");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pair-keyed chained hash table. Commands are
// pushed through the start/busy handshake with random gaps, every result is
// predicted by a behavioral table model kept in the bench and compared field
// by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
  import pkht_pkg::*;

  localparam int NB    = 256;
  localparam int DEPTH = 8;
  localparam int IDLE_LIMIT = 20000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  in_t             in_item = '0;
  logic            out_valid;
  out_t            out_result;
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pair_keyed_chained_hash_table dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_result(out_result), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bench copy of the table contents and registers.
  entry_t      tbl_entry [NB][DEPTH];
  int unsigned tbl_count [NB];
  bit          tbl_used [NB];
  int unsigned mdl_buckets;
  int unsigned mdl_prime_a;
  int unsigned mdl_prime_b;

  in_t  cmd_queue[$];
  out_t expected_results[$];
  int   err_count = 0;
  int   idle_cycles = 0;
  bit   quiet_stretch = 1'b0;
  bit   cfg_pending = 1'b0;
  logic [1:0] cfg_pend_idx;
  logic [CFG_DATA_W-1:0] cfg_pend_data;

  function automatic logic [7:0] hash_bucket(logic [15:0] a, logic [15:0] b);
    longint unsigned n, ha, hb;
    n = mdl_buckets;
    if (n == 0) n = 1;
    if (n > NB) n = NB;
    ha = (longint'(a) * mdl_prime_a) % n;
    hb = (longint'(b) * mdl_prime_b) % n;
    return 8'((ha + hb) % n);
  endfunction

  // Apply one command to the bench table and return its result.
  function automatic out_t table_apply(in_t it);
    out_t r;
    int   bk, hit, k;
    bit   none_used;
    r = '0;
    bk = hash_bucket(it.first_id, it.second_id);
    r.bucket_index = 8'(bk);
    hit = -1;
    for (k = 0; k < tbl_count[bk]; k++)
      if (hit < 0 && tbl_entry[bk][k].first_id == it.first_id &&
          tbl_entry[bk][k].second_id == it.second_id) hit = k;
    case (it.cmd)
      CMD_INSERT: begin
        if (tbl_count[bk] < DEPTH) begin
          tbl_entry[bk][tbl_count[bk]] = '{it.first_id, it.second_id, it.payload};
          tbl_count[bk]++;
        end else begin
          r.overflow = 1'b1;
        end
        tbl_used[bk] = 1'b1;
      end
      CMD_FIND: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          r.payload_out = tbl_entry[bk][hit].handle;
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          for (k = hit; k + 1 < tbl_count[bk]; k++)
            tbl_entry[bk][k] = tbl_entry[bk][k + 1];
          tbl_count[bk]--;
          r.found = 1'b1;
        end
      end
      CMD_CLEAR: begin
        for (k = 0; k < NB; k++) begin
          if (tbl_used[k]) tbl_count[k] = 0;
          tbl_used[k] = 1'b0;
        end
      end
      CMD_UPDATE: begin
        for (k = 0; k < NB; k++)
          if (tbl_count[k] == 0) tbl_used[k] = 1'b0;
      end
      default: ;
    endcase
    none_used = 1'b1;
    for (k = 0; k < NB; k++) if (tbl_used[k]) none_used = 1'b0;
    r.table_empty = none_used;
    return r;
  endfunction

  // Driver: present queued commands, hold start until accepted.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_results = {expected_results, table_apply(in_item)};
      void'(cmd_queue.pop_front());
    end
    if (cfg_pending) begin
      cfg_we <= 1'b1;
      cfg_idx <= cfg_pend_idx;
      cfg_data <= cfg_pend_data;
      cfg_pending = 1'b0;
    end else begin
      cfg_we <= 1'b0;
    end
    if (rst_n && (!start || !busy)) begin
      if (cmd_queue.size() > 0 &&
          (quiet_stretch || $urandom_range(99) >= 15)) begin
        start <= 1'b1;
        in_item <= cmd_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result %p", out_result);
        err_count++;
      end else begin
        out_t e;
        e = expected_results.pop_front();
        if (e.found !== out_result.found) begin
          $error("found: expected %0d, got %0d", e.found, out_result.found); err_count++;
        end
        if (e.payload_out !== out_result.payload_out) begin
          $error("payload_out: expected %0h, got %0h", e.payload_out,
                 out_result.payload_out); err_count++;
        end
        if (e.bucket_index !== out_result.bucket_index) begin
          $error("bucket_index: expected %0d, got %0d", e.bucket_index,
                 out_result.bucket_index); err_count++;
        end
        if (e.table_empty !== out_result.table_empty) begin
          $error("table_empty: expected %0d, got %0d", e.table_empty,
                 out_result.table_empty); err_count++;
        end
        if (e.overflow !== out_result.overflow) begin
          $error("overflow: expected %0d, got %0d", e.overflow,
                 out_result.overflow); err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction or result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_cmd(cmd_t c, logic [15:0] a, logic [15:0] b, logic [15:0] p);
    in_t it;
    it.cmd = c; it.first_id = a; it.second_id = b; it.payload = p;
    cmd_queue = {cmd_queue, it};
  endtask

  task automatic drain();
    wait (cmd_queue.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (2 * NB + 80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_pend_idx = idx;
    cfg_pend_data = val;
    cfg_pending = 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (idx == CFG_NUM_BUCKETS) mdl_buckets = val & 16'h1FF;
    else if (idx == CFG_PRIME_A) mdl_prime_a = val;
    else mdl_prime_b = val;
  endtask

  // Random phase: mostly inserts and lookups on a key pool of the given size.
  task automatic random_phase(int n, int pool);
    int i, r;
    logic [15:0] a, b;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        a = 16'($urandom); b = 16'($urandom);
      end else begin
        a = 16'($urandom_range(pool)); b = 16'($urandom_range(pool));
      end
      r = $urandom_range(99);
      if (r < 40) push_cmd(CMD_INSERT, a, b, 16'($urandom));
      else if (r < 65) push_cmd(CMD_FIND, a, b, 16'($urandom));
      else if (r < 85) push_cmd(CMD_REMOVE, a, b, 16'($urandom));
      else if (r < 88) push_cmd(CMD_CLEAR, a, b, 16'($urandom));
      else if (r < 93) push_cmd(CMD_IS_EMPTY, a, b, 16'($urandom));
      else if (r < 97) push_cmd(CMD_UPDATE, a, b, 16'($urandom));
      else begin
        in_t it;
        it.first_id = 16'($urandom);
        it.second_id = 16'($urandom);
        it.payload = 16'($urandom);
        it.cmd = 3'($urandom_range(6, 7));
        cmd_queue = {cmd_queue, it};
      end
    end
  endtask

  initial begin
    int i;
    mdl_buckets = 256; mdl_prime_a = 73; mdl_prime_b = 151;
    for (i = 0; i < NB; i++) begin
      tbl_count[i] = 0; tbl_used[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every command, overflow, remove shifting, unknown.
    push_cmd(CMD_IS_EMPTY, 16'h0, 16'h0, 16'h0);
    push_cmd(CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_cmd(CMD_FIND, 16'hFFFF, 16'hFFFF, 16'h0);
    push_cmd(CMD_INSERT, 16'h0, 16'h0, 16'h0);
    for (i = 0; i < 9; i++) push_cmd(CMD_INSERT, 16'h5, 16'h7, 16'(i + 100));
    push_cmd(CMD_REMOVE, 16'h5, 16'h7, 16'h0);
    push_cmd(CMD_FIND, 16'h5, 16'h7, 16'h0);
    push_cmd(CMD_REMOVE, 16'h1234, 16'h4321, 16'h0);
    push_cmd(CMD_FIND, 16'h1234, 16'h4321, 16'h0);
    push_cmd(CMD_UPDATE, 16'h0, 16'h0, 16'h0);
    push_cmd(CMD_REMOVE, 16'h0, 16'h0, 16'h0);
    push_cmd(CMD_UPDATE, 16'h0, 16'h0, 16'h0);
    cmd_queue = {cmd_queue, in_t'({3'd6, 16'hAAAA, 16'h5555, 16'hFFFF})};
    cmd_queue = {cmd_queue, in_t'({3'd7, 16'h5555, 16'hAAAA, 16'h0})};
    push_cmd(CMD_CLEAR, 16'h0, 16'h0, 16'h0);
    push_cmd(CMD_IS_EMPTY, 16'h0, 16'h0, 16'h0);
    drain();

    // Random phases across register settings, extremes included.
    quiet_stretch = 1'b1;
    random_phase(150, 40);
    drain();
    quiet_stretch = 1'b0;
    random_phase(150, 40);
    drain();
    write_reg(CFG_NUM_BUCKETS, 16'd1);
    write_reg(CFG_PRIME_A, 16'hFFFF);
    write_reg(CFG_PRIME_B, 16'd1);
    random_phase(150, 20);
    drain();
    write_reg(CFG_NUM_BUCKETS, 16'd0);
    random_phase(100, 20);
    drain();
    write_reg(CFG_NUM_BUCKETS, 16'd511);
    write_reg(CFG_PRIME_B, 16'hFFFF);
    random_phase(150, 60);
    drain();
    write_reg(CFG_NUM_BUCKETS, 16'd7);
    write_reg(CFG_PRIME_A, 16'd1);
    random_phase(200, 30);
    drain();
    write_reg(CFG_NUM_BUCKETS, 16'd256);
    write_reg(CFG_PRIME_A, 16'($urandom_range(1, 65535)));
    write_reg(CFG_PRIME_B, 16'($urandom_range(1, 65535)));
    random_phase(325, 65535);
    drain();

    if (err_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
